@@ rtl/core/jsu_pkg.sv @@
// Shared types, codes and helper functions for the JSON string unescaper.
// Used by the decoder, the result queue and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Event codes on the result channel
  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  // Error codes, valid with EV_ERR
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
  localparam logic [2:0] ERR_CONTROL   = 3'd1;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
  localparam logic [2:0] ERR_SURROGATE = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Most results one input beat can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] event_res;
    logic [2:0] error_code;
  } result_t;

  // Results caused by one input beat, entry 0 delivered first
  typedef struct packed {
    logic [1:0]              cnt;
    result_t [MAX_RES-1:0]   res;
  } group_t;

  function automatic result_t mk_res(input logic [7:0] b, input logic [1:0] ev,
                                     input logic [2:0] err);
    result_t r;
    r.out_byte   = b;
    r.event_res  = ev;
    r.error_code = err;
    return r;
  endfunction

  // Hex digit decode: bit 4 set when the byte is a digit, low nibble its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsu_in_if.sv @@
// Input channel of the JSON string unescaper: one raw text byte per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first;
  logic       input_end;

  modport source (output valid, output in_byte, output first, output input_end,
                  input ready);
  modport sink   (input valid, input in_byte, input first, input input_end,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/jsu_out_if.sv @@
// Result channel of the JSON string unescaper: one decoded byte or event per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] event_res;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output event_res, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input event_res, input error_code,
                  input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/jsu_decode.sv @@
// Parse state and decode logic: turns one input beat into a group of up to three results.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic [7:0]     in_byte,
  input  wire logic           first,
  input  wire logic           input_end,
  output jsu_pkg::group_t     grp
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [4:0]  hex;
  logic [15:0] cp;
  logic [7:0]  esc_byte;
  logic        esc_ok;

  assign hex = jsu_pkg::hex_digit(in_byte);
  assign cp  = {acc_r[11:0], hex[3:0]};

  // Map the escape letter to its byte
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = '0;
    case (in_byte)
      jsu_pkg::CH_QUOTE:     esc_byte = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BACKSLASH: esc_byte = jsu_pkg::CH_BACKSLASH;
      jsu_pkg::CH_SLASH:     esc_byte = jsu_pkg::CH_SLASH;
      jsu_pkg::CH_B:         esc_byte = 8'h08;
      jsu_pkg::CH_F:         esc_byte = 8'h0c;
      jsu_pkg::CH_N:         esc_byte = 8'h0a;
      jsu_pkg::CH_R:         esc_byte = 8'h0d;
      jsu_pkg::CH_T:         esc_byte = 8'h09;
      default:               esc_ok   = 1'b0;
    endcase
  end

  // Decide results and next state for the current beat
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    grp       = '0;
    if (input_end) begin
      if (first) begin
        phase_nxt  = PH_IDLE;
        grp.cnt    = 2'd1;
        grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_NO_QUOTE);
      end else if (phase_r != PH_IDLE && phase_r <= PH_HEX4) begin
        phase_nxt  = PH_IDLE;
        grp.cnt    = 2'd1;
        grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_TRUNCATED);
      end else begin
        phase_nxt = PH_IDLE;
      end
    end else if (first) begin
      acc_nxt = '0;
      if (in_byte != jsu_pkg::CH_QUOTE) begin
        phase_nxt  = PH_IDLE;
        grp.cnt    = 2'd1;
        grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_NO_QUOTE);
      end else begin
        phase_nxt = PH_STR;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_STR: begin
          grp.cnt = 2'd1;
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            phase_nxt  = PH_IDLE;
            grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_DONE, '0);
          end else if (in_byte < jsu_pkg::CH_SPACE) begin
            phase_nxt  = PH_IDLE;
            grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_CONTROL);
          end else if (in_byte == jsu_pkg::CH_BACKSLASH) begin
            phase_nxt = PH_ESC;
            grp.cnt   = 2'd0;
          end else begin
            grp.res[0] = jsu_pkg::mk_res(in_byte, jsu_pkg::EV_BYTE, '0);
          end
        end
        PH_ESC: begin
          if (in_byte == jsu_pkg::CH_U) begin
            acc_nxt   = '0;
            phase_nxt = PH_HEX1;
          end else if (esc_ok) begin
            phase_nxt  = PH_STR;
            grp.cnt    = 2'd1;
            grp.res[0] = jsu_pkg::mk_res(esc_byte, jsu_pkg::EV_BYTE, '0);
          end else begin
            phase_nxt  = PH_IDLE;
            grp.cnt    = 2'd1;
            grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_BAD_ESC);
          end
        end
        PH_HEX1, PH_HEX2, PH_HEX3: begin
          if (!hex[4]) begin
            phase_nxt  = PH_IDLE;
            grp.cnt    = 2'd1;
            grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_BAD_HEX);
          end else begin
            acc_nxt   = cp;
            phase_nxt = phase_t'(phase_r + 3'd1);
          end
        end
        PH_HEX4: begin
          if (!hex[4]) begin
            phase_nxt  = PH_IDLE;
            grp.cnt    = 2'd1;
            grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_BAD_HEX);
          end else begin
            acc_nxt   = cp;
            phase_nxt = PH_STR;
            // Encode the code point as UTF-8; a surrogate code point is an error
            if (cp[15:7] == '0) begin
              grp.cnt    = 2'd1;
              grp.res[0] = jsu_pkg::mk_res(cp[7:0], jsu_pkg::EV_BYTE, '0);
            end else if (cp[15:11] == '0) begin
              grp.cnt    = 2'd2;
              grp.res[0] = jsu_pkg::mk_res({3'b110, cp[10:6]}, jsu_pkg::EV_BYTE, '0);
              grp.res[1] = jsu_pkg::mk_res({2'b10, cp[5:0]}, jsu_pkg::EV_BYTE, '0);
            end else if (cp[15:11] == 5'b11011) begin
              phase_nxt  = PH_IDLE;
              grp.cnt    = 2'd1;
              grp.res[0] = jsu_pkg::mk_res('0, jsu_pkg::EV_ERR, jsu_pkg::ERR_SURROGATE);
            end else begin
              grp.cnt    = 2'd3;
              grp.res[0] = jsu_pkg::mk_res({4'b1110, cp[15:12]}, jsu_pkg::EV_BYTE, '0);
              grp.res[1] = jsu_pkg::mk_res({2'b10, cp[11:6]}, jsu_pkg::EV_BYTE, '0);
              grp.res[2] = jsu_pkg::mk_res({2'b10, cp[5:0]}, jsu_pkg::EV_BYTE, '0);
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Advance parse state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/jsu_outq.sv @@
// Result register: holds one group of up to three results and sends them one per beat.
// Depends on jsu_pkg and jsu_out_if.
`timescale 1ns / 1ps
`default_nettype none

module jsu_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire jsu_pkg::group_t grp,
  output logic                 in_ready,
  jsu_out_if.source            out_ch
);

  jsu_pkg::group_t grp_r;
  logic            valid_r;
  logic [1:0]      idx_r;
  logic            last_res;
  logic            out_fire;
  logic            load;
  jsu_pkg::result_t cur;

  assign cur      = grp_r.res[idx_r];
  assign last_res = (idx_r == grp_r.cnt - 2'd1);
  assign out_fire = valid_r && out_ch.ready;
  assign load     = in_fire && (grp.cnt != 2'd0);

  // Take a new beat when empty or when the final result leaves this cycle
  assign in_ready = !valid_r || (out_ch.ready && last_res);

  assign out_ch.valid      = valid_r;
  assign out_ch.out_byte   = cur.out_byte;
  assign out_ch.event_res  = cur.event_res;
  assign out_ch.error_code = cur.error_code;
  assign out_ch.last       = last_res;

  // Load a group, step through it, drop it after its final result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (out_fire) begin
      if (last_res) begin
        valid_r <= 1'b0;
        idx_r   <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/json_string_unescape_top.sv @@
// JSON string unescaper, top level.
// in_ch: one raw text byte per beat (in_byte, first, input_end), valid/ready.
//   A beat flagged first opens a string and must carry a double quote; input_end
//   marks the end of the text. Bytes outside a string are dropped silently.
// out_ch: one result per beat: a decoded byte, a done event on the closing quote,
//   or an error with its code. last marks the final result of an input beat.
//   A \uXXXX escape yields 1-3 UTF-8 bytes or a surrogate error on its last digit.
// The first result of a beat appears, registered, in the cycle after it is taken.
// Throughput: one input beat per cycle while the receiver is ready and each beat
//   yields at most one result; a beat that yields more holds the input until the
//   single result register, sending one result per beat, has sent the last.
// Reset (rst_n low, synchronous): parse state returns to idle, the result register
//   empties; in_ch.ready is high right after reset.
// Receiver stall: the current result holds on out_ch; one more input beat may be
//   taken in the cycle the final result of a group leaves.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_decode, jsu_outq.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_top (
  input  wire logic clk,
  input  wire logic rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  jsu_pkg::group_t grp;
  logic            in_ready;
  logic            in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  // Decode stage with parse state
  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_ch.in_byte),
    .first     (in_ch.first),
    .input_end (in_ch.input_end),
    .grp       (grp)
  );

  // Result register and serializer
  jsu_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .grp      (grp),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

  // Done and error events always end their group
  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res != jsu_pkg::EV_BYTE |-> out_ch.last)
    else $error("done or error event not marked last");

  // Non-byte events carry a zero byte
  a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res != jsu_pkg::EV_BYTE |-> out_ch.out_byte == 8'h00)
    else $error("event result carries a nonzero byte");

  // Error code only with an error event
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res != jsu_pkg::EV_ERR |-> out_ch.error_code == 3'd0)
    else $error("error code set without error event");

  // Input stalls only behind a pending result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire
